### src/mff_pkg.sv
// ----------------------------------------------------------------------------
// Market feed field fold package
// Frame phase codes, the known-type check and the per-type byte placement functions for the fold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mff_pkg;

   typedef enum logic [2:0] {
      PH_LEN_HI = 3'b001,
      PH_LEN_LO = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] lane;
   } place_type;

   function automatic logic known_type(input logic [7:0] t);
      case (t)
         "S","R","H","Y","L","V","W","K","J","h","A","F",
         "E","C","X","D","U","P","Q","B","I","N","O": known_type = 1'b1;
         default: known_type = 1'b0;
      endcase
   endfunction

   // Byte lane of a field byte at position p; offset o, size s, little-endian le.
   function automatic place_type slot(input logic [15:0] p, input logic [5:0] o,
                                      input logic [3:0] s, input logic le);
      place_type r;
      logic [15:0] d;
      r.hit = 1'b0;
      r.lane = 3'd0;
      d = p - {10'd0, o};
      if (p >= {10'd0, o} && d < {12'd0, s}) begin
         r.hit = 1'b1;
         r.lane = le ? d[2:0] : 3'(s - 4'd1 - d[3:0]);
      end
      return r;
   endfunction

   // XOR contribution of one byte at position p for message type t.
   function automatic logic [63:0] fold_byte(input logic [7:0] t, input logic [15:0] p,
                                             input logic [7:0] b);
      logic [63:0] f;
      place_type q [14];
      logic [3:0] n;
      f = '0;
      n = 4'd0;
      for (int i = 0; i < 14; i++) q[i] = '0;
      case (t)
         "S", "W": begin q[0]=slot(p,11,1,0); end
         "R": begin
            q[0]=slot(p,11,8,1); q[1]=slot(p,21,4,0); q[2]=slot(p,27,2,1);
            q[3]=slot(p,34,4,0); q[4]=slot(p,19,1,0); q[5]=slot(p,20,1,0);
            q[6]=slot(p,25,1,0); q[7]=slot(p,26,1,0); q[8]=slot(p,29,1,0);
            q[9]=slot(p,30,1,0); q[10]=slot(p,31,1,0); q[11]=slot(p,32,1,0);
            q[12]=slot(p,33,1,0); q[13]=slot(p,38,1,0);
         end
         "H": begin
            q[0]=slot(p,11,8,1); q[1]=slot(p,21,4,1); q[2]=slot(p,19,1,0);
            q[3]=slot(p,20,1,0);
         end
         "Y", "N": begin q[0]=slot(p,11,8,1); q[1]=slot(p,19,1,0); end
         "L": begin
            q[0]=slot(p,11,4,1); q[1]=slot(p,15,8,1); q[2]=slot(p,23,1,0);
            q[3]=slot(p,24,1,0); q[4]=slot(p,25,1,0);
         end
         "V": begin q[0]=slot(p,11,8,0); q[1]=slot(p,19,8,0); q[2]=slot(p,27,8,0); end
         "K": begin
            q[0]=slot(p,11,8,1); q[1]=slot(p,19,4,0); q[2]=slot(p,24,4,0);
            q[3]=slot(p,23,1,0);
         end
         "J": begin
            q[0]=slot(p,11,8,1); q[1]=slot(p,19,4,0); q[2]=slot(p,23,4,0);
            q[3]=slot(p,27,4,0); q[4]=slot(p,31,4,0);
         end
         "h": begin q[0]=slot(p,11,8,1); q[1]=slot(p,19,1,0); q[2]=slot(p,20,1,0); end
         "A": begin
            q[0]=slot(p,11,8,0); q[1]=slot(p,20,4,0); q[2]=slot(p,24,8,1);
            q[3]=slot(p,32,4,0); q[4]=slot(p,19,1,0);
         end
         "F": begin
            q[0]=slot(p,11,8,0); q[1]=slot(p,20,4,0); q[2]=slot(p,24,8,1);
            q[3]=slot(p,32,4,0); q[4]=slot(p,36,4,1); q[5]=slot(p,19,1,0);
         end
         "E": begin q[0]=slot(p,11,8,0); q[1]=slot(p,19,4,0); q[2]=slot(p,23,8,0); end
         "C": begin
            q[0]=slot(p,11,8,0); q[1]=slot(p,19,4,0); q[2]=slot(p,23,8,0);
            q[3]=slot(p,32,4,0); q[4]=slot(p,31,1,0);
         end
         "X": begin q[0]=slot(p,11,8,0); q[1]=slot(p,19,4,0); end
         "D", "B": begin q[0]=slot(p,11,8,0); end
         "U": begin
            q[0]=slot(p,11,8,0); q[1]=slot(p,19,8,0); q[2]=slot(p,27,4,0);
            q[3]=slot(p,31,4,0);
         end
         "P": begin
            q[0]=slot(p,11,8,0); q[1]=slot(p,20,4,0); q[2]=slot(p,24,8,1);
            q[3]=slot(p,32,4,0); q[4]=slot(p,36,8,0); q[5]=slot(p,19,1,0);
         end
         "Q": begin
            q[0]=slot(p,11,8,0); q[1]=slot(p,19,8,1); q[2]=slot(p,27,4,0);
            q[3]=slot(p,31,8,0); q[4]=slot(p,39,1,0);
         end
         "I": begin
            q[0]=slot(p,11,8,0); q[1]=slot(p,19,8,0); q[2]=slot(p,28,8,1);
            q[3]=slot(p,36,4,0); q[4]=slot(p,40,4,0); q[5]=slot(p,44,4,0);
            q[6]=slot(p,27,1,0); q[7]=slot(p,48,1,0); q[8]=slot(p,49,1,0);
         end
         "O": begin
            q[0]=slot(p,11,8,1); q[1]=slot(p,20,4,0); q[2]=slot(p,24,4,0);
            q[3]=slot(p,28,4,0); q[4]=slot(p,32,8,0); q[5]=slot(p,40,4,0);
            q[6]=slot(p,44,4,0); q[7]=slot(p,19,1,0);
         end
         default: n = 4'd0;
      endcase
      for (int i = 0; i < 14; i++)
         if (q[i].hit) f = f ^ ({56'd0, b} << {q[i].lane, 3'b000});
      return f ^ {60'd0, n};
   endfunction

endpackage
`default_nettype wire

### src/market_feed_message_field_fold_core.sv
// ----------------------------------------------------------------------------
// Market feed message field fold core
// Byte-serial parser of length-prefixed messages; folds typed fields per
// message into a running checksum and reports one result per message.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req_    | in        | data_byte
//  rsp_    | out       | header fields, fold, checksum, count, flags
//
// One byte per cycle unless a stalled result holds the pipe; the result for the last
// body byte (or the second length byte of an empty message) passes the input register, then the output register.
// Input register feeds the frame logic; the result register sits behind it.
// Reset (synchronous) clears phase, counters, checksum and both valids.
// A stalled result holds the pipe; the input register still fills if empty.
`timescale 1ns / 1ps
`default_nettype none
module market_feed_message_field_fold_core
   import mff_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_msg_type,
   output      logic [15:0] rsp_msg_length,
   output      logic [15:0] rsp_stock_locate,
   output      logic [15:0] rsp_tracking_number,
   output      logic [47:0] rsp_time_stamp,
   output      logic [63:0] rsp_field_fold,
   output      logic [63:0] rsp_running_checksum,
   output      logic [63:0] rsp_message_count,
   output      logic        rsp_type_known,
   output      logic        rsp_length_error
);

   // input register
   logic        in_v_ff;
   logic [7:0]  in_b_ff;
   // frame state
   phase_type   phase_ff, phase_in;
   logic [15:0] len_ff, len_in, pos_ff, pos_in, loc_ff, loc_in, trk_ff, trk_in;
   logic [7:0]  typ_ff, typ_in;
   logic [47:0] tim_ff, tim_in;
   logic [63:0] acc_ff, acc_in, sum_ff, sum_in, cnt_ff, cnt_in;
   logic        emit;
   logic [63:0] fold;
   logic        known;
   logic        step;

   // advance when the result register can take a new result
   assign step      = in_v_ff && !(rsp_valid && rsp_stall);
   assign req_stall = in_v_ff && !step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (!req_stall) begin
         in_v_ff <= req_valid;
      end
      if (!req_stall) in_b_ff <= req_data_byte;
   end

   always_comb begin
      phase_in = phase_ff;
      len_in = len_ff; pos_in = pos_ff; typ_in = typ_ff;
      loc_in = loc_ff; trk_in = trk_ff; tim_in = tim_ff;
      acc_in = acc_ff; sum_in = sum_ff; cnt_in = cnt_ff;
      emit = 1'b0; fold = '0; known = 1'b0;
      unique case (phase_ff)
         PH_LEN_LO: begin
            len_in = {len_ff[7:0], in_b_ff};
            pos_in = '0; typ_in = '0; acc_in = '0;
            loc_in = '0; trk_in = '0; tim_in = '0;
            if (len_in == 16'd0) begin
               phase_in = PH_LEN_HI;
               cnt_in = cnt_ff + 64'd1;
               emit = 1'b1;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (pos_ff == 16'd0) typ_in = in_b_ff;
            else if (pos_ff <= 16'd2) loc_in = {loc_ff[7:0], in_b_ff};
            else if (pos_ff <= 16'd4) trk_in = {trk_ff[7:0], in_b_ff};
            else if (pos_ff <= 16'd10) tim_in = {tim_ff[39:0], in_b_ff};
            if (pos_ff != 16'd0) acc_in = acc_ff ^ fold_byte(typ_ff, pos_ff, in_b_ff);
            known = known_type(typ_in);
            if ({1'b0, pos_ff} + 17'd1 >= {1'b0, len_ff}) begin
               if (known)
                  fold = acc_in ^ {48'd0, loc_in} ^ {48'd0, trk_in} ^ {16'd0, tim_in};
               sum_in = sum_ff + fold;
               cnt_in = cnt_ff + 64'd1;
               phase_in = PH_LEN_HI;
               pos_in = '0;
               emit = 1'b1;
            end else begin
               pos_in = pos_ff + 16'd1;
            end
         end
         default: begin
            len_in = {8'd0, in_b_ff};
            phase_in = PH_LEN_LO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN_HI;
         len_ff <= '0; pos_ff <= '0; typ_ff <= '0; acc_ff <= '0;
         loc_ff <= '0; trk_ff <= '0; tim_ff <= '0;
         sum_ff <= '0; cnt_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         len_ff <= len_in; pos_ff <= pos_in; typ_ff <= typ_in; acc_ff <= acc_in;
         loc_ff <= loc_in; trk_ff <= trk_in; tim_ff <= tim_in;
         sum_ff <= sum_in; cnt_ff <= cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (!(rsp_valid && rsp_stall)) begin
         rsp_valid <= step && emit;
      end
      if (step && emit) begin
         rsp_msg_type         <= typ_in;
         rsp_msg_length       <= len_in;
         rsp_stock_locate     <= loc_in;
         rsp_tracking_number  <= trk_in;
         rsp_time_stamp       <= tim_in;
         rsp_field_fold       <= fold;
         rsp_running_checksum <= sum_in;
         rsp_message_count    <= cnt_in;
         rsp_type_known       <= known;
         rsp_length_error     <= (phase_ff == PH_LEN_LO);
      end
   end

endmodule
`default_nettype wire
